>>> design/rgb_template_correlation_search_defines.svh
// Assertion macros used by the checker file.
`ifndef RGB_TEMPLATE_CORRELATION_SEARCH_DEFINES_SVH
`define RGB_TEMPLATE_CORRELATION_SEARCH_DEFINES_SVH

// Same-cycle implication, sampled on clk_i, off during reset.
`define RTSC_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("rtsc assertion failed");

// Next-cycle implication, sampled on clk_i, off during reset.
`define RTSC_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("rtsc assertion failed");

`endif

>>> design/rtsc_pkg.sv
// ----------------------------------------------------------------------------
// rtsc_pkg
// Types, codes and constants of the RGB template correlation search.
// ----------------------------------------------------------------------------
package rtsc_pkg;

  localparam int unsigned PIX_W      = 24;
  localparam int unsigned CHAN_W     = 8;
  localparam int unsigned NUM_CHAN   = 3;
  localparam int unsigned PSUM_W     = 18;
  localparam int unsigned OUT_SUM_W  = 28;
  localparam int unsigned OFS_W      = 8;
  localparam int unsigned COORD_W    = 7;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 10;
  localparam int unsigned THR_W      = 10;
  localparam int unsigned PERMILLE   = 1000;

  localparam int unsigned DEF_MAX_SRC_W = 128;
  localparam int unsigned DEF_MAX_SRC_H = 128;
  localparam int unsigned DEF_MAX_PAT_W = 32;
  localparam int unsigned DEF_MAX_PAT_H = 32;

  localparam logic [7:0]       RST_SRC_W  = 8'd128;
  localparam logic [7:0]       RST_SRC_H  = 8'd128;
  localparam logic [5:0]       RST_PAT_W  = 6'd32;
  localparam logic [5:0]       RST_PAT_H  = 6'd32;
  localparam logic [THR_W-1:0] RST_THRESH = 10'd900;

  localparam logic [OFS_W-1:0] NO_OFS = 8'hFF;

  typedef enum logic [1:0] {
    CMD_PAT    = 2'd0,
    CMD_SRC    = 2'd1,
    CMD_SEARCH = 2'd2
  } cmd_e;

  typedef enum logic [1:0] {
    ST_EXACT     = 2'd0,
    ST_FOUND     = 2'd1,
    ST_NOT_FOUND = 2'd2
  } status_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SRC_W  = 3'd0,
    REG_SRC_H  = 3'd1,
    REG_PAT_W  = 3'd2,
    REG_PAT_H  = 3'd3,
    REG_THRESH = 3'd4
  } reg_idx_e;

  typedef enum logic [2:0] {
    S_IDLE, S_AUTO, S_AUTO_DRAIN, S_SCAN, S_SCAN_DRAIN, S_EVAL, S_MULT, S_VERDICT
  } state_e;

  typedef struct packed {
    logic              valid;
    logic [PIX_W-1:0]  pat;
    logic [PIX_W-1:0]  src;
    logic [PSUM_W-1:0] psum;
  } cell_t;

endpackage

>>> design/rtsc_ifs.sv
// ----------------------------------------------------------------------------
// rtsc channel interfaces
// Command, result and register write channels with valid/ready.
// ----------------------------------------------------------------------------
interface rtsc_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  cmd;
  logic [6:0]  col;
  logic [6:0]  row;
  logic [23:0] pixel_rgb;
  modport source (output valid, cmd, col, row, pixel_rgb, input ready);
  modport sink (input valid, cmd, col, row, pixel_rgb, output ready);
endinterface

interface rtsc_out_if;
  logic              valid;
  logic              ready;
  logic [1:0]        status;
  logic signed [7:0] best_x;
  logic signed [7:0] best_y;
  logic [27:0]       best_sum;
  logic [27:0]       auto_sum;
  modport source (output valid, status, best_x, best_y, best_sum, auto_sum, input ready);
  modport sink (input valid, status, best_x, best_y, best_sum, auto_sum, output ready);
endinterface

interface rtsc_cfg_if;
  logic       valid;
  logic       ready;
  logic [2:0] idx;
  logic [9:0] data;
  modport source (output valid, idx, data, input ready);
  modport sink (input valid, idx, data, output ready);
endinterface

>>> design/rtsc_cell.sv
// ----------------------------------------------------------------------------
// rtsc_cell
// One colour channel product: add low byte product, pass pixels on shifted.
// ----------------------------------------------------------------------------
module rtsc_cell (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  rtsc_pkg::cell_t     cell_i,
  output rtsc_pkg::cell_t     cell_o
);

  logic                          valid_q;
  logic [rtsc_pkg::PIX_W-1:0]    pat_q;
  logic [rtsc_pkg::PIX_W-1:0]    src_q;
  logic [rtsc_pkg::PSUM_W-1:0]   psum_q;
  logic [2*rtsc_pkg::CHAN_W-1:0] prod;

  assign prod = cell_i.pat[rtsc_pkg::CHAN_W-1:0] * cell_i.src[rtsc_pkg::CHAN_W-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= cell_i.valid;
    end
  end

  // shift so the next cell sees the next channel in its low byte
  always_ff @(posedge clk_i) begin
    pat_q  <= cell_i.pat >> rtsc_pkg::CHAN_W;
    src_q  <= cell_i.src >> rtsc_pkg::CHAN_W;
    psum_q <= cell_i.psum + rtsc_pkg::PSUM_W'(prod);
  end

  assign cell_o.valid = valid_q;
  assign cell_o.pat   = pat_q;
  assign cell_o.src   = src_q;
  assign cell_o.psum  = psum_q;

endmodule

>>> design/rgb_template_correlation_search.sv
// ----------------------------------------------------------------------------
// rgb_template_correlation_search
// Template search over an RGB source image by exact cross-correlation.
// ----------------------------------------------------------------------------
// Pixel writes (cmd 0 pattern, cmd 1 source) give no result. A search first
// sums the pattern autocorrelation, then for every offset streams the pw*ph
// pixel pairs out of the two image memories, one pair per cycle through a row
// of three channel cells into an accumulator. Each image memory has a single
// read port. An exact match ends the scan early; the MULT and VERDICT states
// form the verdict, which shows on the result channel in the cycle after VERDICT.
// No new item is taken while a search runs; a search waits while a result
// is held.
module rgb_template_correlation_search #(
  parameter int unsigned MAX_SRC_W = rtsc_pkg::DEF_MAX_SRC_W,
  parameter int unsigned MAX_SRC_H = rtsc_pkg::DEF_MAX_SRC_H,
  parameter int unsigned MAX_PAT_W = rtsc_pkg::DEF_MAX_PAT_W,
  parameter int unsigned MAX_PAT_H = rtsc_pkg::DEF_MAX_PAT_H
) (
  input logic         clk_i,
  input logic         rst_ni,
  rtsc_in_if.sink     in_i,
  rtsc_out_if.source  out_o,
  rtsc_cfg_if.sink    cfg_i
);

  localparam int unsigned PAT_DEPTH = MAX_PAT_W * MAX_PAT_H;
  localparam int unsigned SRC_DEPTH = MAX_SRC_W * MAX_SRC_H;
  localparam int unsigned PAW = (PAT_DEPTH > 1) ? $clog2(PAT_DEPTH) : 1;
  localparam int unsigned SAW = (SRC_DEPTH > 1) ? $clog2(SRC_DEPTH) : 1;
  localparam int unsigned PXW = $clog2(MAX_PAT_W + 1);
  localparam int unsigned PYW = $clog2(MAX_PAT_H + 1);
  localparam int unsigned SXW = $clog2(MAX_SRC_W + 1);
  localparam int unsigned SYW = $clog2(MAX_SRC_H + 1);
  localparam longint unsigned MAX_SUM = longint'(PAT_DEPTH) * 64'd195075;
  localparam int unsigned ACCW  = $clog2(MAX_SUM + 1);
  localparam int unsigned PRODW = ACCW + rtsc_pkg::THR_W;
  localparam int unsigned NC    = rtsc_pkg::NUM_CHAN;

  // configuration registers
  logic [7:0]                 cfg_sw_q, cfg_sh_q;
  logic [5:0]                 cfg_pw_q, cfg_ph_q;
  logic [rtsc_pkg::THR_W-1:0] cfg_thr_q;

  rtsc_pkg::state_e state_q, state_d;

  logic [PXW-1:0] pw_c, pw_q, pw_d, x_q, x_d;
  logic [PYW-1:0] ph_c, ph_q, ph_d, y_q, y_d;
  logic [SXW-1:0] sw_c, xlim_q, xlim_d, xo_q, xo_d;
  logic [SYW-1:0] sh_c, ylim_q, ylim_d, yo_q, yo_d;
  logic           fits_c, fits_q, fits_d;
  logic           have_q, have_d, exact_q, exact_d;
  logic [ACCW-1:0] acc_q, auto_q, auto_d, best_q, best_d;
  logic [rtsc_pkg::OFS_W-1:0] bx_q, bx_d, by_q, by_d;
  logic [PRODW-1:0] prod_b_q, prod_b_d, prod_a_q, prod_a_d;
  logic           acc_clr;

  logic                    out_valid_q, out_valid_d;
  rtsc_pkg::status_e       status_q, status_d;
  logic [rtsc_pkg::OFS_W-1:0] obx_q, obx_d, oby_q, oby_d;
  logic [rtsc_pkg::OUT_SUM_W-1:0] obest_q, obest_d, oauto_q, oauto_d;

  logic in_acc, start, issue, issue_last, busy, upd, hit, last_ofs;
  logic pat_we, src_we;
  logic [PAW-1:0] pat_waddr, pat_raddr;
  logic [SAW-1:0] src_waddr, src_raddr;

  logic [rtsc_pkg::PIX_W-1:0] pat_mem [PAT_DEPTH];
  logic [rtsc_pkg::PIX_W-1:0] src_mem [SRC_DEPTH];
  logic [rtsc_pkg::PIX_W-1:0] pat_rd_q, src_rd_q;
  logic                       rd_vld_q, rd_auto_q;

  rtsc_pkg::cell_t stage [NC+1];

  // ---------------- handshakes ----------------
  assign in_i.ready = (state_q == rtsc_pkg::S_IDLE) &&
                      !(in_i.cmd == rtsc_pkg::CMD_SEARCH && out_valid_q);
  assign in_acc = in_i.valid && in_i.ready;
  assign start  = in_acc && (in_i.cmd == rtsc_pkg::CMD_SEARCH);
  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_sw_q  <= rtsc_pkg::RST_SRC_W;
      cfg_sh_q  <= rtsc_pkg::RST_SRC_H;
      cfg_pw_q  <= rtsc_pkg::RST_PAT_W;
      cfg_ph_q  <= rtsc_pkg::RST_PAT_H;
      cfg_thr_q <= rtsc_pkg::RST_THRESH;
    end else if (cfg_i.valid) begin
      case (cfg_i.idx)
        rtsc_pkg::REG_SRC_W:  cfg_sw_q  <= cfg_i.data[7:0];
        rtsc_pkg::REG_SRC_H:  cfg_sh_q  <= cfg_i.data[7:0];
        rtsc_pkg::REG_PAT_W:  cfg_pw_q  <= cfg_i.data[5:0];
        rtsc_pkg::REG_PAT_H:  cfg_ph_q  <= cfg_i.data[5:0];
        rtsc_pkg::REG_THRESH: cfg_thr_q <= cfg_i.data;
        default: ;
      endcase
    end
  end

  // ---------------- clamped sizes ----------------
  always_comb begin
    if (cfg_pw_q == '0) pw_c = PXW'(1);
    else if (32'(cfg_pw_q) > MAX_PAT_W) pw_c = PXW'(MAX_PAT_W);
    else pw_c = PXW'(cfg_pw_q);
    if (cfg_ph_q == '0) ph_c = PYW'(1);
    else if (32'(cfg_ph_q) > MAX_PAT_H) ph_c = PYW'(MAX_PAT_H);
    else ph_c = PYW'(cfg_ph_q);
    if (cfg_sw_q == '0) sw_c = SXW'(1);
    else if (32'(cfg_sw_q) > MAX_SRC_W) sw_c = SXW'(MAX_SRC_W);
    else sw_c = SXW'(cfg_sw_q);
    if (cfg_sh_q == '0) sh_c = SYW'(1);
    else if (32'(cfg_sh_q) > MAX_SRC_H) sh_c = SYW'(MAX_SRC_H);
    else sh_c = SYW'(cfg_sh_q);
    fits_c = (32'(pw_c) <= 32'(sw_c)) && (32'(ph_c) <= 32'(sh_c));
  end

  // ---------------- image memories ----------------
  assign pat_we = in_acc && (in_i.cmd == rtsc_pkg::CMD_PAT) &&
                  (32'(in_i.col) < MAX_PAT_W) && (32'(in_i.row) < MAX_PAT_H);
  assign src_we = in_acc && (in_i.cmd == rtsc_pkg::CMD_SRC) &&
                  (32'(in_i.col) < MAX_SRC_W) && (32'(in_i.row) < MAX_SRC_H);
  assign pat_waddr = PAW'(32'(in_i.row) * MAX_PAT_W + 32'(in_i.col));
  assign src_waddr = SAW'(32'(in_i.row) * MAX_SRC_W + 32'(in_i.col));
  assign pat_raddr = PAW'(32'(y_q) * MAX_PAT_W + 32'(x_q));
  assign src_raddr = SAW'((32'(yo_q) + 32'(y_q)) * MAX_SRC_W + 32'(xo_q) + 32'(x_q));

  always_ff @(posedge clk_i) begin
    if (pat_we) pat_mem[pat_waddr] <= in_i.pixel_rgb;
    pat_rd_q <= pat_mem[pat_raddr];
  end

  always_ff @(posedge clk_i) begin
    if (src_we) src_mem[src_waddr] <= in_i.pixel_rgb;
    src_rd_q <= src_mem[src_raddr];
  end

  // ---------------- cell row ----------------
  assign issue      = (state_q == rtsc_pkg::S_AUTO) || (state_q == rtsc_pkg::S_SCAN);
  assign issue_last = (x_q == pw_q - PXW'(1)) && (y_q == ph_q - PYW'(1));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_vld_q  <= 1'b0;
      rd_auto_q <= 1'b0;
    end else begin
      rd_vld_q  <= issue;
      rd_auto_q <= (state_q == rtsc_pkg::S_AUTO);
    end
  end

  assign stage[0].valid = rd_vld_q;
  assign stage[0].pat   = pat_rd_q;
  assign stage[0].src   = rd_auto_q ? pat_rd_q : src_rd_q;
  assign stage[0].psum  = '0;

  for (genvar k = 0; k < NC; k++) begin : g_cell
    rtsc_cell u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .cell_i (stage[k]),
      .cell_o (stage[k+1])
    );
  end

  always_comb begin
    busy = rd_vld_q;
    for (int k = 1; k <= NC; k++) busy = busy | stage[k].valid;
  end

  always_ff @(posedge clk_i) begin
    if (acc_clr) acc_q <= '0;
    else if (stage[NC].valid) acc_q <= acc_q + ACCW'(stage[NC].psum);
  end

  // ---------------- sequencer ----------------
  assign upd      = !have_q || (acc_q >= best_q);
  assign hit      = upd && (acc_q == auto_q);
  assign last_ofs = (xo_q == xlim_q) && (yo_q == ylim_q);

  always_comb begin
    state_d = state_q;
    case (state_q)
      rtsc_pkg::S_IDLE:       if (start) state_d = rtsc_pkg::S_AUTO;
      rtsc_pkg::S_AUTO:       if (issue_last) state_d = rtsc_pkg::S_AUTO_DRAIN;
      rtsc_pkg::S_AUTO_DRAIN: begin
        if (!busy) state_d = fits_q ? rtsc_pkg::S_SCAN : rtsc_pkg::S_MULT;
      end
      rtsc_pkg::S_SCAN:       if (issue_last) state_d = rtsc_pkg::S_SCAN_DRAIN;
      rtsc_pkg::S_SCAN_DRAIN: if (!busy) state_d = rtsc_pkg::S_EVAL;
      rtsc_pkg::S_EVAL: begin
        state_d = (hit || last_ofs) ? rtsc_pkg::S_MULT : rtsc_pkg::S_SCAN;
      end
      rtsc_pkg::S_MULT:       state_d = rtsc_pkg::S_VERDICT;
      rtsc_pkg::S_VERDICT:    state_d = rtsc_pkg::S_IDLE;
      default:                state_d = rtsc_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    pw_d = pw_q; ph_d = ph_q; xlim_d = xlim_q; ylim_d = ylim_q; fits_d = fits_q;
    x_d = x_q; y_d = y_q; xo_d = xo_q; yo_d = yo_q;
    have_d = have_q; exact_d = exact_q; auto_d = auto_q; best_d = best_q;
    bx_d = bx_q; by_d = by_q; prod_b_d = prod_b_q; prod_a_d = prod_a_q;
    acc_clr = 1'b0;
    out_valid_d = out_valid_q && !out_o.ready;
    status_d = status_q; obx_d = obx_q; oby_d = oby_q;
    obest_d = obest_q; oauto_d = oauto_q;
    case (state_q)
      rtsc_pkg::S_IDLE: begin
        if (start) begin
          pw_d = pw_c; ph_d = ph_c; fits_d = fits_c;
          xlim_d = SXW'(32'(sw_c) - 32'(pw_c));
          ylim_d = SYW'(32'(sh_c) - 32'(ph_c));
          x_d = '0; y_d = '0; xo_d = '0; yo_d = '0;
          have_d = 1'b0; exact_d = 1'b0; best_d = '0;
          bx_d = rtsc_pkg::NO_OFS; by_d = rtsc_pkg::NO_OFS;
          acc_clr = 1'b1;
        end
      end
      rtsc_pkg::S_AUTO, rtsc_pkg::S_SCAN: begin
        if (x_q == pw_q - PXW'(1)) begin
          x_d = '0;
          y_d = (y_q == ph_q - PYW'(1)) ? '0 : y_q + PYW'(1);
        end else begin
          x_d = x_q + PXW'(1);
        end
      end
      rtsc_pkg::S_AUTO_DRAIN: begin
        if (!busy) begin
          auto_d  = acc_q;
          acc_clr = 1'b1;
        end
      end
      rtsc_pkg::S_EVAL: begin
        if (upd) begin
          have_d = 1'b1;
          best_d = acc_q;
          bx_d   = rtsc_pkg::OFS_W'(xo_q);
          by_d   = rtsc_pkg::OFS_W'(yo_q);
          if (acc_q == auto_q) exact_d = 1'b1;
        end
        // advance to the next offset, row by row
        if (xo_q == xlim_q) begin
          xo_d = '0;
          yo_d = yo_q + SYW'(1);
        end else begin
          xo_d = xo_q + SXW'(1);
        end
        acc_clr = 1'b1;
      end
      rtsc_pkg::S_MULT: begin
        prod_b_d = PRODW'(best_q) * PRODW'(rtsc_pkg::PERMILLE);
        prod_a_d = PRODW'(auto_q) * PRODW'(cfg_thr_q);
      end
      rtsc_pkg::S_VERDICT: begin
        if (!have_q) status_d = rtsc_pkg::ST_NOT_FOUND;
        else if (exact_q) status_d = rtsc_pkg::ST_EXACT;
        else if (prod_b_q < prod_a_q) status_d = rtsc_pkg::ST_NOT_FOUND;
        else status_d = rtsc_pkg::ST_FOUND;
        obx_d   = bx_q;
        oby_d   = by_q;
        obest_d = rtsc_pkg::OUT_SUM_W'(best_q);
        oauto_d = rtsc_pkg::OUT_SUM_W'(auto_q);
        out_valid_d = 1'b1;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= rtsc_pkg::S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pw_q <= pw_d; ph_q <= ph_d; xlim_q <= xlim_d; ylim_q <= ylim_d; fits_q <= fits_d;
    x_q <= x_d; y_q <= y_d; xo_q <= xo_d; yo_q <= yo_d;
    have_q <= have_d; exact_q <= exact_d; auto_q <= auto_d; best_q <= best_d;
    bx_q <= bx_d; by_q <= by_d; prod_b_q <= prod_b_d; prod_a_q <= prod_a_d;
    status_q <= status_d; obx_q <= obx_d; oby_q <= oby_d;
    obest_q <= obest_d; oauto_q <= oauto_d;
  end

  assign out_o.valid    = out_valid_q;
  assign out_o.status   = status_q;
  assign out_o.best_x   = obx_q;
  assign out_o.best_y   = oby_q;
  assign out_o.best_sum = obest_q;
  assign out_o.auto_sum = oauto_q;

endmodule

>>> design/rtsc_checker.sv
// ----------------------------------------------------------------------------
// rtsc_checker
// Port-level checks of the correlation search, bound to the top level.
// ----------------------------------------------------------------------------
`include "rgb_template_correlation_search_defines.svh"

module rtsc_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_ready_i,
  input logic [1:0]  in_cmd_i,
  input logic        out_valid_i,
  input logic        out_ready_i,
  input logic [1:0]  out_status_i,
  input logic [27:0] out_best_sum_i,
  input logic [27:0] out_auto_sum_i
);

  logic search_acc;
  assign search_acc = in_valid_i && in_ready_i && (in_cmd_i == rtsc_pkg::CMD_SEARCH);

  `RTSC_ASSERT_NEXT(a_out_hold, out_valid_i && !out_ready_i, out_valid_i)
  `RTSC_ASSERT_NEXT(a_search_no_early, search_acc, !out_valid_i)
  `RTSC_ASSERT_NOW(a_status_code, out_valid_i, out_status_i != 2'd3)
  `RTSC_ASSERT_NOW(a_exact_sum, out_valid_i && (out_status_i == rtsc_pkg::ST_EXACT),
                   out_best_sum_i == out_auto_sum_i)

endmodule

bind rgb_template_correlation_search rtsc_checker u_rtsc_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .in_valid_i     (in_i.valid),
  .in_ready_i     (in_i.ready),
  .in_cmd_i       (in_i.cmd),
  .out_valid_i    (out_o.valid),
  .out_ready_i    (out_o.ready),
  .out_status_i   (out_o.status),
  .out_best_sum_i (out_o.best_sum),
  .out_auto_sum_i (out_o.auto_sum)
);
